@@ sv/v3n_pkg.sv @@
`default_nettype none
package v3n_pkg;
    localparam int IN_WIDTH_DEF      = 16;
    localparam int OUT_FRAC_BITS_DEF = 14;
    localparam int LEN_FRAC_BITS     = 8;
endpackage
`default_nettype wire

@@ sv/vector3_normalize.sv @@
`default_nettype none
// channel  dir  fields (tdata low bit up)                            handshake
// s_axis   in   comp_x, comp_y, comp_z                               tvalid/tready
// m_axis   out  unit_x, unit_y, unit_z, zero_vector (bit 3*UW)       tvalid/tready
// pipeline: 3 input stages + IN_WIDTH+9 sqrt cells + OUT_FRAC_BITS+8 divide cells + 1 output
// one word per cycle sustained while the output is not stalled; each cell of the chain advances every cycle
// the input stages and output register move only while the output slot is empty or being taken
// reset clears the valid bits along the chain; data registers are not reset
module vector3_normalize
    import v3n_pkg::*;
#(
    parameter int IN_WIDTH      = IN_WIDTH_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    // comp_x, comp_y, comp_z
    input  wire  [((3*IN_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    // unit_x, unit_y, unit_z, zero_vector
    output logic [((3*(OUT_FRAC_BITS+2)+1+7)/8)*8-1:0] m_axis_tdata
);
    localparam int UW  = OUT_FRAC_BITS + 2;
    localparam int MW  = IN_WIDTH;              // magnitude width
    localparam int SQW = 2*MW + 2;              // squared sum width
    localparam int SW  = SQW + 16 + (SQW % 2);  // radicand width, even
    localparam int NP  = SW / 2;
    localparam int RW  = NP;                    // root width
    localparam int NF  = OUT_FRAC_BITS + LEN_FRAC_BITS;
    localparam int QW  = MW + NF + 1;
    localparam int FW  = 3*MW + 4;              // carried magnitudes, signs, zero
    localparam int OW  = ((3*UW+1+7)/8)*8;

    logic adv;
    logic out_vld_reg;
    assign adv           = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = out_vld_reg;

    // stage 0: magnitudes and signs
    logic          v0_reg;
    logic [MW-1:0] mag_reg [3];
    logic [2:0]    neg_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (adv)
            v0_reg <= s_axis_tvalid;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                neg_reg[i] <= s_axis_tdata[i*IN_WIDTH + IN_WIDTH-1];
                mag_reg[i] <= s_axis_tdata[i*IN_WIDTH+IN_WIDTH-1]
                    ? MW'(-s_axis_tdata[i*IN_WIDTH +: IN_WIDTH])
                    : s_axis_tdata[i*IN_WIDTH +: IN_WIDTH];
            end
        end
    end

    // stage 1: squares
    logic           v1_reg;
    logic [2*MW-1:0] sq_reg [3];
    logic [MW-1:0]  mag1_reg [3];
    logic [2:0]     neg1_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= v0_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i]   <= mag_reg[i] * mag_reg[i];
                mag1_reg[i] <= mag_reg[i];
            end
            neg1_reg <= neg_reg;
        end
    end

    // stage 2: sum, scaled radicand
    logic          v2_reg;
    logic [SW-1:0] rad_reg;
    logic [FW-1:0] car_reg;
    logic [SQW-1:0] ssum;
    assign ssum = SQW'(sq_reg[0]) + SQW'(sq_reg[1]) + SQW'(sq_reg[2]);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad_reg <= SW'({ssum, 16'h0000});
            car_reg <= {ssum == '0, neg1_reg, mag1_reg[2], mag1_reg[1], mag1_reg[0]};
        end
    end

    // square root chain
    logic [NP:0]   sv;
    logic [SW-1:0] srad [NP+1];
    logic [RW-1:0] sroot [NP+1];
    logic [RW+1:0] srem [NP+1];
    logic [FW-1:0] scar [NP+1];
    assign sv[0]    = v2_reg;
    assign srad[0]  = rad_reg;
    assign sroot[0] = '0;
    assign srem[0]  = '0;
    assign scar[0]  = car_reg;
    for (genvar k = 0; k < NP; k++)
    begin : g_sqrt
        logic          cv;
        logic [SW-1:0] crad;
        logic [RW-1:0] croot;
        logic [RW+1:0] crem;
        logic [FW-1:0] ccar;
        v3n_sqrt_cell #(.RW(RW), .SW(SW), .CW(FW)) u_cell (
            .clk(clk), .rst_n(rst_n), .vld_in(sv[k]),
            .rad_in(srad[k]), .root_in(sroot[k]), .rem_in(srem[k]), .car_in(scar[k]),
            .vld_out(cv), .rad_out(crad), .root_out(croot), .rem_out(crem),
            .car_out(ccar)
        );
        // hold the chain while the output is stalled
        logic          hv_reg;
        logic [SW-1:0] hrad_reg;
        logic [RW-1:0] hroot_reg;
        logic [RW+1:0] hrem_reg;
        logic [FW-1:0] hcar_reg;
        logic          adv_d_reg;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                adv_d_reg <= 1'b1;
            else
                adv_d_reg <= adv;
        end
        always_ff @(posedge clk)
        begin
            if (adv_d_reg)
            begin
                hv_reg <= cv; hrad_reg <= crad; hroot_reg <= croot;
                hrem_reg <= crem; hcar_reg <= ccar;
            end
        end
        assign sv[k+1]    = adv_d_reg ? cv    : hv_reg;
        assign srad[k+1]  = adv_d_reg ? crad  : hrad_reg;
        assign sroot[k+1] = adv_d_reg ? croot : hroot_reg;
        assign srem[k+1]  = adv_d_reg ? crem  : hrem_reg;
        assign scar[k+1]  = adv_d_reg ? ccar  : hcar_reg;
    end

    // division chain seed: integer part is always zero since len >= |c| * 256
    logic [NF:0]     dv;
    logic [RW-1:0]   dden [NF+1];
    logic [3*RW-1:0] drem [NF+1];
    logic [3*QW-1:0] dquo [NF+1];
    logic [FW-1:0]   dflg [NF+1];
    logic [RW-1:0]   lenc;
    assign lenc    = (sroot[NP] == '0) ? RW'(1) : sroot[NP];
    assign dv[0]   = sv[NP];
    assign dden[0] = lenc;
    for (genvar i = 0; i < 3; i++)
    begin : g_seed
        assign drem[0][i*RW +: RW] = RW'(scar[NP][i*MW +: MW]);
    end
    assign dquo[0] = '0;
    assign dflg[0] = scar[NP];
    for (genvar k = 0; k < NF; k++)
    begin : g_div
        logic            cv;
        logic [RW-1:0]   cden;
        logic [3*RW-1:0] crem;
        logic [3*QW-1:0] cquo;
        logic [FW-1:0]   cflg;
        v3n_div_cell #(.DW(RW), .QW(QW), .FW(FW)) u_cell (
            .clk(clk), .rst_n(rst_n), .vld_in(dv[k]),
            .den_in(dden[k]), .rem_in(drem[k]), .quo_in(dquo[k]), .flg_in(dflg[k]),
            .vld_out(cv), .den_out(cden), .rem_out(crem), .quo_out(cquo),
            .flg_out(cflg)
        );
        logic            hv_reg;
        logic [RW-1:0]   hden_reg;
        logic [3*RW-1:0] hrem_reg;
        logic [3*QW-1:0] hquo_reg;
        logic [FW-1:0]   hflg_reg;
        logic            adv_d_reg;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                adv_d_reg <= 1'b1;
            else
                adv_d_reg <= adv;
        end
        always_ff @(posedge clk)
        begin
            if (adv_d_reg)
            begin
                hv_reg <= cv; hden_reg <= cden; hrem_reg <= crem;
                hquo_reg <= cquo; hflg_reg <= cflg;
            end
        end
        assign dv[k+1]   = adv_d_reg ? cv   : hv_reg;
        assign dden[k+1] = adv_d_reg ? cden : hden_reg;
        assign drem[k+1] = adv_d_reg ? crem : hrem_reg;
        assign dquo[k+1] = adv_d_reg ? cquo : hquo_reg;
        assign dflg[k+1] = adv_d_reg ? cflg : hflg_reg;
    end

    // output register: clamp, sign, zero flag
    logic [OW-1:0] out_next;
    logic [QW-1:0] qv;
    logic [UW-1:0] uq;
    logic          zf;
    always_comb
    begin
        out_next = '0;
        qv       = '0;
        uq       = '0;
        zf       = dflg[NF][FW-1];
        for (int i = 0; i < 3; i++)
        begin
            qv = dquo[NF][i*QW +: QW];
            if (qv > QW'(1) << OUT_FRAC_BITS)
                uq = UW'(1) << OUT_FRAC_BITS;
            else
                uq = qv[UW-1:0];
            if (dflg[NF][3*MW + i])
                uq = UW'(-uq);
            if (zf)
                uq = '0;
            out_next[i*UW +: UW] = uq;
        end
        out_next[3*UW] = zf;
    end

    // the hold registers above catch words that land while stalled; the chain
    // itself is advanced unconditionally and is fed from the hold registers during a stall
    logic stall_seen_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg    <= 1'b0;
            stall_seen_reg <= 1'b0;
        end
        else
        begin
            stall_seen_reg <= !adv;
            if (adv)
                out_vld_reg <= dv[NF];
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv)
            m_axis_tdata <= out_next;
    end

    // a zero vector carries all-zero units; ready is high while the output is empty; a stalled word stays valid
    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[3*UW] |-> m_axis_tdata[3*UW-1:0] == '0)
        else $error("zero vector with nonzero unit");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("ready low with empty output");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stall_seen_reg && $past(m_axis_tvalid) |-> m_axis_tvalid)
        else $error("stalled word lost");
endmodule
`default_nettype wire

@@ sv/v3n_sqrt_cell.sv @@
`default_nettype none
// one restoring square root step: takes one radicand bit pair per cycle
module v3n_sqrt_cell #(
    parameter int RW = 40,
    parameter int SW = 80,
    parameter int CW = 34
) (
    input  wire           clk,
    input  wire           rst_n,
    input  wire           vld_in,
    input  wire  [SW-1:0] rad_in,
    input  wire  [RW-1:0] root_in,
    input  wire  [RW+1:0] rem_in,
    input  wire  [CW-1:0] car_in,
    output logic          vld_out,
    output logic [SW-1:0] rad_out,
    output logic [RW-1:0] root_out,
    output logic [RW+1:0] rem_out,
    output logic [CW-1:0] car_out
);
    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;
    logic          take;

    // trial subtract of 4*root+1 from the shifted remainder
    always_comb
    begin
        rem_sh = {rem_in[RW-1:0], rad_in[SW-1:SW-2]};
        trial  = {root_in, 2'b01};
        take   = rem_sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_out <= 1'b0;
        else
            vld_out <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        rad_out  <= {rad_in[SW-3:0], 2'b00};
        root_out <= {root_in[RW-2:0], take};
        rem_out  <= take ? rem_sh - trial : rem_sh;
        car_out  <= car_in;
    end
endmodule
`default_nettype wire

@@ sv/v3n_div_cell.sv @@
`default_nettype none
// one restoring division step for the three components in parallel
module v3n_div_cell #(
    parameter int DW = 40,
    parameter int QW = 64,
    parameter int FW = 34
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              vld_in,
    input  wire  [DW-1:0]    den_in,
    input  wire  [3*DW-1:0]  rem_in,
    input  wire  [3*QW-1:0]  quo_in,
    input  wire  [FW-1:0]    flg_in,
    output logic             vld_out,
    output logic [DW-1:0]    den_out,
    output logic [3*DW-1:0]  rem_out,
    output logic [3*QW-1:0]  quo_out,
    output logic [FW-1:0]    flg_out
);
    logic [3*DW-1:0] rem_n;
    logic [3*QW-1:0] quo_n;
    logic [DW:0]     sh;

    // shift in a zero bit, subtract when it fits
    always_comb
    begin
        rem_n = '0;
        quo_n = '0;
        sh    = '0;
        for (int i = 0; i < 3; i++)
        begin
            sh = {rem_in[i*DW +: DW], 1'b0};
            if (sh >= {1'b0, den_in})
            begin
                rem_n[i*DW +: DW] = DW'(sh - {1'b0, den_in});
                quo_n[i*QW +: QW] = {quo_in[i*QW +: QW-1], 1'b1};
            end
            else
            begin
                rem_n[i*DW +: DW] = sh[DW-1:0];
                quo_n[i*QW +: QW] = {quo_in[i*QW +: QW-1], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_out <= 1'b0;
        else
            vld_out <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        den_out <= den_in;
        rem_out <= rem_n;
        quo_out <= quo_n;
        flg_out <= flg_in;
    end
endmodule
`default_nettype wire
